// ===== sv/spectrum_bar_smoother_macros.svh =====
// ----------------------------------------------------------------------------
// spectrum bar smoother assertion macros
// concurrent property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAR_SMOOTHER_MACROS_SVH
`define SPECTRUM_BAR_SMOOTHER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spectrum_bar_smoother: same-cycle property violated");

// next-cycle implication
`define SBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spectrum_bar_smoother: next-cycle property violated");

`else

`define SBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg
// shared types and constants of the spectrum bar smoother
// ----------------------------------------------------------------------------
`default_nettype none

package sbs_pkg;

  localparam int unsigned MaxBands  = 64;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned HeightW   = 20;
  localparam int unsigned CoefBits  = 16;
  localparam int unsigned LowBandEnd = 8;
  localparam int unsigned MidBandEnd = 18;

  // spatial and blend weights over 2^16
  localparam logic [15:0] WCenter  = 16'd55050;
  localparam logic [15:0] WSide    = 16'd5243;
  localparam logic [15:0] AtkKeep  = 16'd1311;
  localparam logic [15:0] AtkApply = 16'd62259;
  localparam logic [15:0] RelKeep  = 16'd20972;
  localparam logic [15:0] RelApply = 16'd44564;
  localparam logic [15:0] CoefHalf = 16'd32768;
  localparam logic [19:0] HeightMax = 20'hFFFFF;

  // register reset values
  localparam logic [15:0] EnergyFloorRst = 16'd512;
  localparam logic [9:0]  LowGainRst     = 10'd538;
  localparam logic [9:0]  MidGainRst     = 10'd397;
  localparam logic [9:0]  HighGainRst    = 10'd302;
  localparam logic [13:0] HeightScaleRst = 14'd10752;
  localparam logic [7:0]  JitterGateRst  = 8'd46;
  localparam logic [15:0] RiseLimitRst   = 16'd4096;
  localparam logic [15:0] FallLimitRst   = 16'd2048;

  // square root unit sizing
  localparam int unsigned SqrtOpW   = 30;
  localparam int unsigned SqrtRootW = 15;

  typedef enum logic [2:0] {
    RegEnergyFloor = 3'd0,
    RegLowGain     = 3'd1,
    RegMidGain     = 3'd2,
    RegHighGain    = 3'd3,
    RegHeightScale = 3'd4,
    RegJitterGate  = 3'd5,
    RegRiseLimit   = 3'd6,
    RegFallLimit   = 3'd7
  } reg_idx_e;

  typedef enum logic [9:0] {
    StIdle  = 10'b00_0000_0001,
    StGain  = 10'b00_0000_0010,
    StSqrt  = 10'b00_0000_0100,
    StScale = 10'b00_0000_1000,
    StRead  = 10'b00_0001_0000,
    StMulC  = 10'b00_0010_0000,
    StMulS  = 10'b00_0100_0000,
    StLimit = 10'b00_1000_0000,
    StMulK  = 10'b01_0000_0000,
    StMulA  = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic signed [19:0] band_energy;
    logic               frame_end;
  } in_t;

  typedef struct packed {
    logic [19:0] bar_height;
    logic [5:0]  band_index;
    logic        last_of_frame;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/sbs_ram.sv =====
// ----------------------------------------------------------------------------
// sbs_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_ram #(
  parameter int unsigned Width = 20,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/sbs_sqrt.sv =====
// ----------------------------------------------------------------------------
// sbs_sqrt
// restoring integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_sqrt (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [sbs_pkg::SqrtOpW-1:0]     op_i,
  output logic                                 busy_o,
  output logic      [sbs_pkg::SqrtRootW-1:0]   root_o
);

  localparam int unsigned OpW   = sbs_pkg::SqrtOpW;
  localparam int unsigned RootW = sbs_pkg::SqrtRootW;
  localparam int unsigned CntW  = $clog2(RootW + 1);

  logic [OpW-1:0]   op_q, op_d;
  logic [RootW:0]   rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;

  logic [RootW+2:0] rem_sh;
  logic [RootW+2:0] trial;
  logic [RootW+2:0] diff;

  always_comb begin
    rem_sh = {rem_q, op_q[OpW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = rem_sh - trial;
    op_d   = op_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      op_d   = op_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      op_d = {op_q[OpW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = diff[RootW:0];
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[RootW:0];
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(RootW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ===== sv/spectrum_bar_smoother.sv =====
// ----------------------------------------------------------------------------
// spectrum_bar_smoother
// per-band target height, 3-tap spatial smoothing and attack/release store
// ----------------------------------------------------------------------------
//   channel  direction  payload        handshake
//   in       input      sbs_pkg::in_t  in_valid_i / in_stall_o
//   out      output     sbs_pkg::out_t out_valid_o / out_stall_i
//   cfg      input      8 registers    apb psel/penable/pwrite, pready high
//
// one band at a time: the target (gain multiply, 15-step square root,
// scale), then each result through the height memory read-modify-write;
// the last band of a longer frame gives two results, band 0 of a longer
// frame has no result yet, other bands give one each.
// the next band is taken while a result waits in the output register; a
// result that cannot enter the output register holds the sequencer.
// reset clears the per-band valid bits at once, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_bar_smoother #(
  parameter int unsigned MAX_BANDS = sbs_pkg::MaxBands
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire sbs_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output sbs_pkg::out_t      out_data_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready
);

  localparam int unsigned CW = $clog2(MAX_BANDS);

  // configuration registers
  logic [15:0] floor_q, rise_q, fall_q;
  logic [9:0]  lgain_q, mgain_q, hgain_q;
  logic [13:0] hscale_q;
  logic [7:0]  jgate_q;
  sbs_pkg::reg_idx_e reg_idx;
  logic cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = sbs_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= sbs_pkg::EnergyFloorRst;
      lgain_q  <= sbs_pkg::LowGainRst;
      mgain_q  <= sbs_pkg::MidGainRst;
      hgain_q  <= sbs_pkg::HighGainRst;
      hscale_q <= sbs_pkg::HeightScaleRst;
      jgate_q  <= sbs_pkg::JitterGateRst;
      rise_q   <= sbs_pkg::RiseLimitRst;
      fall_q   <= sbs_pkg::FallLimitRst;
    end else if (cfg_we) begin
      case (reg_idx)
        sbs_pkg::RegEnergyFloor: floor_q  <= pwdata[15:0];
        sbs_pkg::RegLowGain:     lgain_q  <= pwdata[9:0];
        sbs_pkg::RegMidGain:     mgain_q  <= pwdata[9:0];
        sbs_pkg::RegHighGain:    hgain_q  <= pwdata[9:0];
        sbs_pkg::RegHeightScale: hscale_q <= pwdata[13:0];
        sbs_pkg::RegJitterGate:  jgate_q  <= pwdata[7:0];
        sbs_pkg::RegRiseLimit:   rise_q   <= pwdata[15:0];
        sbs_pkg::RegFallLimit:   fall_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sbs_pkg::RegEnergyFloor: prdata = {16'd0, floor_q};
      sbs_pkg::RegLowGain:     prdata = {22'd0, lgain_q};
      sbs_pkg::RegMidGain:     prdata = {22'd0, mgain_q};
      sbs_pkg::RegHighGain:    prdata = {22'd0, hgain_q};
      sbs_pkg::RegHeightScale: prdata = {18'd0, hscale_q};
      sbs_pkg::RegJitterGate:  prdata = {24'd0, jgate_q};
      sbs_pkg::RegRiseLimit:   prdata = {16'd0, rise_q};
      sbs_pkg::RegFallLimit:   prdata = {16'd0, fall_q};
      default:                 prdata = '0;
    endcase
  end

  // sequencer state
  sbs_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [19:0]   tp_q, tp_d, tp2_q, tp2_d;
  logic          phase_q, phase_d;
  logic          out_valid_q, out_valid_d;
  sbs_pkg::out_t out_q, out_d;

  // payload registers
  logic [18:0]   ef_q, ef_d;
  logic [9:0]    g_q, g_d;
  logic [CW-1:0] i_q, i_d;
  logic          last_q, last_d;
  logic [19:0]   t_q, t_d;
  logic [19:0]   c_q, c_d;
  logic [20:0]   side_q, side_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [35:0]   acc_q, acc_d;
  logic [19:0]   cur_q, cur_d;
  logic [19:0]   sp_q, sp_d;
  logic [19:0]   sp2_q, sp2_d;
  logic          atk_q, atk_d;

  logic [MAX_BANDS-1:0] valid_q;

  // datapath helpers
  logic [18:0] e_pos;
  logic [CW-1:0] i_in;
  logic [28:0] gprod;
  logic [sbs_pkg::SqrtOpW-1:0] sq_op;
  logic sq_start, sq_busy;
  logic [sbs_pkg::SqrtRootW-1:0] sq_root;
  logic [28:0] sc;
  logic [CW-1:0] idx_sel;
  logic [19:0] l_sel, c_sel, r_sel;
  logic [33:0] sprod;
  logic [36:0] ssum;
  logic [19:0] sp_j, mag;
  logic [35:0] aprod;
  logic [36:0] asum;
  logic [19:0] res;
  logic [31:0] idx32;
  logic [19:0] rdata;
  logic ram_we;
  logic out_free;
  logic in_acc;

  assign in_stall_o = (state_q != sbs_pkg::StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !(out_valid_q && out_stall_i);

  sbs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .op_i    (sq_op),
    .busy_o  (sq_busy),
    .root_o  (sq_root)
  );

  sbs_ram #(
    .Width (sbs_pkg::HeightW),
    .Depth (MAX_BANDS)
  ) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (res),
    .raddr_i (idx_sel),
    .rdata_o (rdata)
  );

  always_comb begin
    // clamp negative energy, then the dead zone
    e_pos = in_data_i.band_energy[19] ? 19'd0 : in_data_i.band_energy[18:0];
    i_in  = cnt_q;
    gprod = ef_q * g_q;
    sq_op = {1'b0, gprod[28:8], 8'd0};
    sc    = sq_root * hscale_q;

    if (!phase_q) begin
      idx_sel = i_q - CW'(1);
      l_sel   = (i_q == CW'(1)) ? tp_q : tp2_q;
      c_sel   = tp_q;
      r_sel   = t_q;
    end else begin
      idx_sel = i_q;
      l_sel   = (i_q != '0) ? tp_q : t_q;
      c_sel   = t_q;
      r_sel   = t_q;
    end

    sprod = side_q * sbs_pkg::WSide;
    ssum  = 37'(acc_q) + 37'(sprod) + 37'(sbs_pkg::CoefHalf);

    // jitter gate, then rise and fall limits
    mag  = (sp_q > cur_q) ? sp_q - cur_q : cur_q - sp_q;
    sp_j = (mag < 20'(jgate_q)) ? cur_q : sp_q;

    aprod = sp2_q * (atk_q ? sbs_pkg::AtkApply : sbs_pkg::RelApply);
    asum  = 37'(acc_q) + 37'(aprod) + 37'(sbs_pkg::CoefHalf);
    res   = asum[36] ? sbs_pkg::HeightMax : asum[35:16];
    idx32 = 32'(idx_q);
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    tp_d        = tp_q;
    tp2_d       = tp2_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ef_d        = ef_q;
    g_d         = g_q;
    i_d         = i_q;
    last_d      = last_q;
    t_d         = t_q;
    c_d         = c_q;
    side_d      = side_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    cur_d       = cur_q;
    sp_d        = sp_q;
    sp2_d       = sp2_q;
    atk_d       = atk_q;
    sq_start    = 1'b0;
    ram_we      = 1'b0;

    case (state_q)
      sbs_pkg::StIdle: begin
        if (in_acc) begin
          ef_d   = (e_pos < 19'(floor_q)) ? 19'd0 : e_pos - 19'(floor_q);
          i_d    = i_in;
          last_d = in_data_i.frame_end || (cnt_q == CW'(MAX_BANDS - 1));
          if (32'(i_in) < sbs_pkg::LowBandEnd) begin
            g_d = lgain_q;
          end else if (32'(i_in) < sbs_pkg::MidBandEnd) begin
            g_d = mgain_q;
          end else begin
            g_d = hgain_q;
          end
          state_d = sbs_pkg::StGain;
        end
      end
      sbs_pkg::StGain: begin
        sq_start = 1'b1;
        state_d  = sbs_pkg::StSqrt;
      end
      sbs_pkg::StSqrt: begin
        if (!sq_busy) begin
          state_d = sbs_pkg::StScale;
        end
      end
      sbs_pkg::StScale: begin
        t_d     = sc[28] ? sbs_pkg::HeightMax : sc[27:8];
        phase_d = (i_q == '0);
        if ((i_q == '0) && !last_q) begin
          // first band of a longer frame only fills the target history
          cnt_d   = i_q + CW'(1);
          tp2_d   = tp_q;
          tp_d    = t_d;
          state_d = sbs_pkg::StIdle;
        end else begin
          state_d = sbs_pkg::StRead;
        end
      end
      sbs_pkg::StRead: begin
        c_d     = c_sel;
        side_d  = 21'(l_sel) + 21'(r_sel);
        idx_d   = idx_sel;
        state_d = sbs_pkg::StMulC;
      end
      sbs_pkg::StMulC: begin
        acc_d   = c_q * sbs_pkg::WCenter;
        cur_d   = valid_q[idx_q] ? rdata : 20'd0;
        state_d = sbs_pkg::StMulS;
      end
      sbs_pkg::StMulS: begin
        sp_d    = ssum[36] ? sbs_pkg::HeightMax : ssum[35:16];
        state_d = sbs_pkg::StLimit;
      end
      sbs_pkg::StLimit: begin
        sp2_d = sp_j;
        if (sp_j > cur_q) begin
          if ((sp_j - cur_q) > 20'(rise_q)) begin
            sp2_d = cur_q + 20'(rise_q);
          end
        end else if ((cur_q - sp_j) > 20'(fall_q)) begin
          sp2_d = cur_q - 20'(fall_q);
        end
        state_d = sbs_pkg::StMulK;
      end
      sbs_pkg::StMulK: begin
        atk_d   = sp2_q > cur_q;
        acc_d   = cur_q * ((sp2_q > cur_q) ? sbs_pkg::AtkKeep : sbs_pkg::RelKeep);
        state_d = sbs_pkg::StMulA;
      end
      sbs_pkg::StMulA: begin
        if (out_free) begin
          ram_we                  = 1'b1;
          out_valid_d             = 1'b1;
          out_d.bar_height        = res;
          out_d.band_index        = idx32[5:0];
          out_d.last_of_frame     = phase_q;
          if (!phase_q && last_q) begin
            phase_d = 1'b1;
            state_d = sbs_pkg::StRead;
          end else begin
            cnt_d   = last_q ? '0 : i_q + CW'(1);
            tp2_d   = tp_q;
            tp_d    = t_q;
            state_d = sbs_pkg::StIdle;
          end
        end
      end
      default: state_d = sbs_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbs_pkg::StIdle;
      cnt_q       <= '0;
      tp_q        <= '0;
      tp2_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tp_q        <= tp_d;
      tp2_q       <= tp2_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    ef_q   <= ef_d;
    g_q    <= g_d;
    i_q    <= i_d;
    last_q <= last_d;
    t_q    <= t_d;
    c_q    <= c_d;
    side_q <= side_d;
    idx_q  <= idx_d;
    acc_q  <= acc_d;
    cur_q  <= cur_d;
    sp_q   <= sp_d;
    sp2_q  <= sp2_d;
    atk_q  <= atk_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "spectrum_bar_smoother_macros.svh"

  `SBS_ASSERT_NXT(a_accept_starts_gain, clk_i, rst_ni, in_acc, state_q == sbs_pkg::StGain)
  `SBS_ASSERT_NXT(a_write_loads_output, clk_i, rst_ni, ram_we, out_valid_q)
  `SBS_ASSERT_IMP(a_write_needs_room, clk_i, rst_ni, ram_we, !(out_valid_q && out_stall_i))

endmodule

`default_nettype wire
